@@ sv/sdtq_pkg.sv @@
// Shared types and constants of the sorted deadline timer queue.
`timescale 1ns / 1ps
`default_nettype none

package sdtq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_RESULTS = 16;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int DUE_W       = $clog2(MAX_RESULTS + 1);

   localparam int TIME_W  = 32;
   localparam int DELAY_W = 16;
   localparam int TAG_W   = 8;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK   = 2'd0;
   localparam status_type STATUS_FULL = 2'd1;
   localparam status_type STATUS_TICK = 2'd2;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_COMPARE,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      logic               valid;
      logic [TIME_W-1:0]  expiry;
      logic [TAG_W-1:0]   tag;
      logic [DELAY_W-1:0] delay;
   } entry_type;

   typedef struct packed {
      cell_op_type        op;
      logic [TIME_W-1:0]  new_expiry;
      logic [TAG_W-1:0]   new_tag;
      logic [DELAY_W-1:0] new_delay;
   } cell_cmd_type;

endpackage

`default_nettype wire

@@ sv/sorted_deadline_timer_queue.sv @@
// Top level of the sorted deadline timer queue: controller, time base and the chain of cells.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps up to QUEUE_DEPTH alarms in a chain of cells, sorted by expiry time with the
// earliest at the head. An insert transaction (func 0) stores expiry = current time + delay
// ahead of every alarm that expires at the same time or later, and answers with one result
// (status 0, or status 1 when the queue is full and the alarm is dropped). A tick transaction
// (func 1) advances the time by one and reports every alarm now due, earliest first, one
// result per cycle while rsp_ready stays high, with last set on the final one; a tick with
// nothing due gives no result. At most MAX_RESULTS alarms fire per tick; the rest fire on
// the next tick. Time and expiry values wrap modulo 2^32 and compare over a half range.
// One transaction is in work at a time: an insert goes through accept, compare in every
// cell, then shift and answer; a tick pops the due alarms one by one through the head cell.
// A result consumer that holds rsp_ready low stalls both.

module sorted_deadline_timer_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic                req_func,
   input  wire logic [15:0]         req_delay_ticks,
   input  wire logic [7:0]          req_alarm_tag,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic                rsp_fired,
   output      logic [7:0]          rsp_fired_tag,
   output      logic [15:0]         rsp_fired_delay,
   output      sdtq_pkg::status_type rsp_status,
   output      logic                rsp_last
);
   import sdtq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_INSERT,
      ST_POP
   } state_type;

   state_type          state_ff, state_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIME_W-1:0]  new_expiry_ff, new_expiry_in;
   logic [TAG_W-1:0]   new_tag_ff, new_tag_in;
   logic [DELAY_W-1:0] new_delay_ff, new_delay_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DUE_W-1:0]   due_cnt_ff, due_cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_fired_ff, rsp_fired_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic [DELAY_W-1:0] rsp_delay_ff, rsp_delay_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   cell_cmd_type       cmd;
   entry_type          cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0] take_chain;
   entry_type          empty_entry;

   logic               out_free;
   logic               full;
   logic               req_fire;
   logic [TIME_W-1:0]  head_age, next_age;
   logic               head_due, next_due;

   assign empty_entry = '0;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign full        = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;

   // The head alarm is due once the current time is at or after its expiry. The second
   // entry tells whether the result that pops the head is the last one of this tick.
   assign head_age = now_ff - cell_entry[0].expiry;
   assign next_age = now_ff - cell_entry[1].expiry;
   assign head_due = cell_entry[0].valid && !head_age[TIME_W-1]
                     && (due_cnt_ff < DUE_W'(MAX_RESULTS));
   assign next_due = cell_entry[1].valid && !next_age[TIME_W-1]
                     && ((due_cnt_ff + 1'b1) < DUE_W'(MAX_RESULTS));

   // Command broadcast to every cell.
   always_comb begin
      cmd.op         = CELL_HOLD;
      cmd.new_expiry = new_expiry_ff;
      cmd.new_tag    = new_tag_ff;
      cmd.new_delay  = new_delay_ff;
      case (state_ff)
         ST_COMPARE: cmd.op = CELL_COMPARE;
         ST_INSERT:  if (out_free && !full) cmd.op = CELL_INSERT;
         ST_POP:     if (out_free && head_due) cmd.op = CELL_POP;
         default:    cmd.op = CELL_HOLD;
      endcase
   end

   // The insert position is found by a take flag that ripples from the head down the chain.
   assign take_chain[0] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_e, right_e;
      if (i == 0) begin : g_head
         assign left_e = empty_entry;
      end else begin : g_body
         assign left_e = cell_entry[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_e = empty_entry;
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end
      sdtq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_e),
         .right_entry (right_e),
         .take_before (take_chain[i]),
         .entry       (cell_entry[i]),
         .take_after  (take_chain[i+1])
      );
   end

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      new_expiry_in = new_expiry_ff;
      new_tag_in    = new_tag_ff;
      new_delay_in  = new_delay_ff;
      count_in      = count_ff;
      due_cnt_in    = due_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_fired_in  = rsp_fired_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_delay_in  = rsp_delay_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_func == FUNC_TICK) begin
                  now_in     = now_ff + 1'b1;
                  due_cnt_in = '0;
                  state_in   = ST_POP;
               end else begin
                  new_expiry_in = now_ff + TIME_W'(req_delay_ticks);
                  new_tag_in    = req_alarm_tag;
                  new_delay_in  = req_delay_ticks;
                  state_in      = ST_COMPARE;
               end
            end
         end
         ST_COMPARE: begin
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_fired_in  = 1'b0;
               rsp_tag_in    = '0;
               rsp_delay_in  = '0;
               rsp_status_in = full ? STATUS_FULL : STATUS_OK;
               rsp_last_in   = 1'b1;
               if (!full) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            if (!head_due) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_fired_in  = 1'b1;
               rsp_tag_in    = cell_entry[0].tag;
               rsp_delay_in  = cell_entry[0].delay;
               rsp_status_in = STATUS_TICK;
               rsp_last_in   = !next_due;
               count_in      = count_ff - 1'b1;
               due_cnt_in    = due_cnt_ff + 1'b1;
               if (!next_due) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         count_ff     <= '0;
         due_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         count_ff     <= count_in;
         due_cnt_ff   <= due_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      new_expiry_ff <= new_expiry_in;
      new_tag_ff    <= new_tag_in;
      new_delay_ff  <= new_delay_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_delay_ff  <= rsp_delay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired       = rsp_fired_ff;
   assign rsp_fired_tag   = rsp_tag_ff;
   assign rsp_fired_delay = rsp_delay_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

@@ sv/sdtq_cell.sv @@
// One slot of the sorted alarm chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module sdtq_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sdtq_pkg::cell_cmd_type cmd,
   input  wire sdtq_pkg::entry_type   left_entry,
   input  wire sdtq_pkg::entry_type   right_entry,
   input  wire logic                  take_before,
   output      sdtq_pkg::entry_type   entry,
   output      logic                  take_after
);
   import sdtq_pkg::*;

   entry_type         entry_ff, entry_in;
   logic              ge_ff, ge_in;
   logic [TIME_W-1:0] diff;

   // The stored alarm is at or after the new expiry when the wrapped difference is not negative.
   assign diff = entry_ff.expiry - cmd.new_expiry;

   always_comb begin
      entry_in = entry_ff;
      ge_in    = ge_ff;
      case (cmd.op)
         CELL_COMPARE: begin
            // An empty slot always takes the new alarm if no earlier slot did.
            ge_in = !entry_ff.valid || !diff[TIME_W-1];
         end
         CELL_INSERT: begin
            if (take_before) begin
               entry_in = left_entry;
            end else if (ge_ff) begin
               entry_in.valid  = 1'b1;
               entry_in.expiry = cmd.new_expiry;
               entry_in.tag    = cmd.new_tag;
               entry_in.delay  = cmd.new_delay;
            end
         end
         CELL_POP: begin
            entry_in = right_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.expiry <= entry_in.expiry;
      entry_ff.tag    <= entry_in.tag;
      entry_ff.delay  <= entry_in.delay;
      ge_ff           <= ge_in;
   end

   assign entry      = entry_ff;
   assign take_after = take_before | ge_ff;

endmodule

`default_nettype wire
